// ===== rtl/rlh_pkg.sv =====
// ----------------------------------------------------------------------------
// rlh_pkg
// shared widths, constants, types and the rgb565 luma bin function
// ----------------------------------------------------------------------------
package rlh_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int NUM_BINS        = 16;
  localparam int BIN_W           = $clog2(NUM_BINS);
  localparam int PIXEL_W         = 16;
  localparam int BIN_COUNT_W     = 32;

  localparam logic [5:0] COEF_R = 6'd38;
  localparam logic [6:0] COEF_G = 7'd75;
  localparam logic [3:0] COEF_B = 4'd15;

  localparam int LUMA_SUM_W = 13;
  localparam int LUMA_SHIFT = 5;

  typedef logic [PIXEL_W-1:0] rlh_pixel_t;
  typedef logic [BIN_W-1:0]   rlh_bin_t;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_WAIT = 3'b010,
    ST_DUMP = 3'b100
  } rlh_state_t;

  function automatic rlh_bin_t rlh_bin_of(input rlh_pixel_t pix);
    logic [4:0]            r;
    logic [5:0]            g;
    logic [4:0]            b;
    logic [LUMA_SUM_W-1:0] sum;
    logic [7:0]            luma;
    r    = pix[15:11];
    g    = pix[10:5];
    b    = pix[4:0];
    sum  = LUMA_SUM_W'(r) * LUMA_SUM_W'(COEF_R)
         + LUMA_SUM_W'(g) * LUMA_SUM_W'(COEF_G)
         + LUMA_SUM_W'(b) * LUMA_SUM_W'(COEF_B);
    luma = 8'(sum >> LUMA_SHIFT);
    return luma[7:4];
  endfunction

endpackage

// ===== rtl/rlh_pix_if.sv =====
// ----------------------------------------------------------------------------
// rlh_pix_if
// pixel stream channel: valid/ready with pixel and frame end flag
// ----------------------------------------------------------------------------
interface rlh_pix_if;
  import rlh_pkg::*;

  logic       valid;
  logic       ready;
  rlh_pixel_t pixel;
  logic       frame_end;

  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

// ===== rtl/rlh_bin_if.sv =====
// ----------------------------------------------------------------------------
// rlh_bin_if
// histogram result channel: valid/ready with bin index, count and last flag
// ----------------------------------------------------------------------------
interface rlh_bin_if;
  import rlh_pkg::*;

  logic                   valid;
  logic                   ready;
  rlh_bin_t               bin_index;
  logic [BIN_COUNT_W-1:0] bin_count;
  logic                   last_bin;

  modport source (output valid, output bin_index, output bin_count, output last_bin,
                  input ready);
  modport sink   (input valid, input bin_index, input bin_count, input last_bin,
                  output ready);
endinterface

// ===== rtl/rgb565_luma_histogram.sv =====
// ----------------------------------------------------------------------------
// rgb565_luma_histogram
// 16-bin luma histogram over an rgb565 pixel stream
//
// in_pix carries one pixel per transaction; frame_end marks the last pixel of
// a frame. each pixel is counted in bin luma>>4 of a 16-entry counter memory,
// with luma = (r*38 + g*75 + b*15) >> 5; counters saturate at all ones.
// pixels are taken at one per clock outside the read-out: a read-modify-write
// on the counter memory, with the previous write forwarded when two pixels hit
// one bin. after the frame_end transaction in_pix.ready stays low through a
// drain state and the whole read-out: the 16 bins go out on out_bin in order,
// each via a memory read, then the output register, no new read being issued
// while one is pending; last_bin set on bin 15. a stall on out_bin holds the
// output register and pauses the read-out.
// each bin is cleared as it is read. reset clears per-bin valid bits, so
// all counters read as zero right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module rgb565_luma_histogram #(
  parameter int COUNT_WIDTH = rlh_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rlh_pix_if.sink          in_pix,
  rlh_bin_if.source        out_bin
);
  import rlh_pkg::*;

  localparam rlh_bin_t LAST_BIN = BIN_W'(NUM_BINS - 1);

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    val_r;

  rlh_state_t state_r, state_nxt;
  rlh_bin_t   dk_r, dk_nxt;

  logic                   in_fire;
  rlh_bin_t               in_bin;
  logic                   dump_issue;
  logic                   rd_en;
  rlh_bin_t               rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_val_r;
  logic                   rd_pend_r;
  rlh_bin_t               pk_r;

  logic                   s1_vld_r;
  rlh_bin_t               s1_bin_r;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;

  logic                   wr_vld_r;
  rlh_bin_t               wr_bin_r;
  logic [COUNT_WIDTH-1:0] wr_data_r;

  logic                   out_vld_r;
  rlh_bin_t               out_idx_r;
  logic [BIN_COUNT_W-1:0] out_cnt_r;
  logic                   out_last_r;

  assign in_pix.ready = (state_r == ST_RUN);
  assign in_fire      = in_pix.valid && in_pix.ready;
  assign in_bin       = rlh_bin_of(in_pix.pixel);

  assign dump_issue = (state_r == ST_DUMP) && !rd_pend_r && (!out_vld_r || out_bin.ready);
  assign rd_en      = in_fire || dump_issue;
  assign rd_addr    = (state_r == ST_DUMP) ? dk_r : in_bin;

  // read-modify-write with forwarding of the last write
  always_comb begin
    if (wr_vld_r && (wr_bin_r == s1_bin_r)) begin
      cur = wr_data_r;
    end else if (rd_val_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
    inc = (&cur) ? cur : cur + COUNT_WIDTH'(1);
  end

  always_comb begin
    state_nxt = state_r;
    dk_nxt    = dk_r;
    case (state_r)
      ST_RUN: begin
        if (in_fire && in_pix.frame_end) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DUMP;
        dk_nxt    = '0;
      end
      ST_DUMP: begin
        if (dump_issue) begin
          dk_nxt = dk_r + BIN_W'(1);
          if (dk_r == LAST_BIN) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_val_r  <= val_r[rd_addr];
    end
    if (s1_vld_r) begin
      mem[s1_bin_r] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    s1_bin_r  <= in_bin;
    wr_bin_r  <= s1_bin_r;
    wr_data_r <= inc;
    if (dump_issue) begin
      pk_r <= dk_r;
    end
    if (rd_pend_r) begin
      out_idx_r  <= pk_r;
      out_cnt_r  <= BIN_COUNT_W'(rd_val_r ? rd_data_r : '0);
      out_last_r <= (pk_r == LAST_BIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      dk_r      <= '0;
      val_r     <= '0;
      s1_vld_r  <= 1'b0;
      wr_vld_r  <= 1'b0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dk_r      <= dk_nxt;
      s1_vld_r  <= in_fire;
      wr_vld_r  <= s1_vld_r;
      rd_pend_r <= dump_issue;
      if (s1_vld_r) begin
        val_r[s1_bin_r] <= 1'b1;
      end
      if (dump_issue) begin
        val_r[dk_r] <= 1'b0;
      end
      if (rd_pend_r) begin
        out_vld_r <= 1'b1;
      end else if (out_bin.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_bin.valid     = out_vld_r;
  assign out_bin.bin_index = out_idx_r;
  assign out_bin.bin_count = out_cnt_r;
  assign out_bin.last_bin  = out_last_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb565 luma histogram
//
// pixel frames go in over in_pix; a scoreboard keeps its own bin counters,
// queues the 16 bin reports each frame end should produce and compares every
// out_bin transaction field by field. the block is built with 16-bit
// counters. three phases vary idling on both channels, and the sender
// sometimes waits for the histogram read-out to finish before it goes on.
// ----------------------------------------------------------------------------
module tb_top;
  import rlh_pkg::*;

  localparam int CNT_W = 16;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam int RAND_PER_PHASE = 40;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    rlh_bin_t               idx;
    logic [BIN_COUNT_W-1:0] count;
    logic                   last;
  } bin_rec_t;

  class luma_hist_board;
    bin_rec_t    want_q[$];
    int unsigned bin_tally[NUM_BINS];
    int unsigned errors;
    int unsigned pixels_seen;
    int unsigned frames_seen;
    int unsigned bins_seen;

    function rlh_bin_t bin_of(input rlh_pixel_t pix);
      int unsigned luma;
      luma = (int'(pix[15:11]) * 38 + int'(pix[10:5]) * 75 + int'(pix[4:0]) * 15) >> 5;
      return rlh_bin_t'(luma >> 4);
    endfunction

    function void note_pixel(input rlh_pixel_t pix, input logic fe);
      rlh_bin_t b;
      bin_rec_t rec;
      b = bin_of(pix);
      pixels_seen++;
      if (bin_tally[b] < CNT_MAX) bin_tally[b]++;
      if (fe) begin
        frames_seen++;
        for (int k = 0; k < NUM_BINS; k++) begin
          rec.idx   = rlh_bin_t'(k);
          rec.count = BIN_COUNT_W'(bin_tally[k]);
          rec.last  = (k == NUM_BINS - 1);
          want_q.push_back(rec);
          bin_tally[k] = 0;
        end
      end
    endfunction

    function void check_bin(input bin_rec_t got);
      bin_rec_t want;
      bins_seen++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected bin transaction idx %0d count %0d last %0b",
                 $time, got.idx, got.count, got.last);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.idx !== want.idx) begin
        $display("%0t: bin_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: bin_count (bin %0d) expected %0d actual %0d",
                 $time, want.idx, want.count, got.count);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_bin (bin %0d) expected %0b actual %0b",
                 $time, want.idx, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   cycle_count = 0;
  luma_hist_board hist = new();

  rlh_pix_if pix_if ();
  rlh_bin_if bin_if ();

  rgb565_luma_histogram #(
    .COUNT_WIDTH (CNT_W)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_bin (bin_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bin reports still pending", $time, hist.want_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver ready and transaction monitors
  always @(posedge clk) begin
    bin_rec_t got;
    if (!rst_n) begin
      bin_if.ready <= 1'b0;
    end else begin
      bin_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (pix_if.valid && pix_if.ready) hist.note_pixel(pix_if.pixel, pix_if.frame_end);
      if (bin_if.valid && bin_if.ready) begin
        got.idx   = bin_if.bin_index;
        got.count = bin_if.bin_count;
        got.last  = bin_if.last_bin;
        hist.check_bin(got);
      end
    end
  end

  task automatic send_pixel(input rlh_pixel_t pix, input logic fe);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    pix_if.valid     <= 1'b1;
    pix_if.pixel     <= pix;
    pix_if.frame_end <= fe;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (hist.want_q.size() != 0);
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct);
    int         sent;
    int         len;
    rlh_pixel_t pix;
    rlh_pixel_t prev;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    prev = '0;
    while (sent < RAND_PER_PHASE) begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        // repeats hit the same bin on back-to-back transactions
        if ($urandom_range(0, 3) == 0) pix = prev;
        else pix = rlh_pixel_t'($urandom_range(0, 16'hFFFF));
        send_pixel(pix, i == len - 1);
        prev = pix;
        sent++;
      end
      if (sent == len || $urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    pix_if.valid     = 1'b0;
    pix_if.pixel     = '0;
    pix_if.frame_end = 1'b0;
    src_idle_pct     = 0;
    snk_idle_pct     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-pixel frames, field extremes, bins near the top
    src_idle_pct = 30;
    snk_idle_pct = 64;
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8410, 1'b0);
    send_pixel(16'h7BEF, 1'b0);
    send_pixel(16'hFFDF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    wait_drained();

    run_phase(30, 64);
    wait_drained();
    run_phase(64, 30);
    wait_drained();
    run_phase(0, 0);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("pixels %0d, frames %0d, bin reports checked %0d",
             hist.pixels_seen, hist.frames_seen, hist.bins_seen);
    $display("idle mixes: sender-heavy, receiver-heavy, none; single-pixel and same-bin runs");
    if (hist.errors == 0 && hist.want_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d bin reports never seen", hist.errors, hist.want_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
